FILE: src/base64_stream_decoder_core_defines.svh
// Assertion macros for the base64 stream decoder.
`ifndef BASE64_STREAM_DECODER_CORE_DEFINES_SVH
`define BASE64_STREAM_DECODER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define B64D_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("b64d same-cycle check failed");
`define B64D_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("b64d next-cycle check failed");
`else
`define B64D_ASSERT_SAME(label, ante, cons)
`define B64D_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: src/b64d_pkg.sv
package b64d_pkg;

	localparam logic [1:0] REQ_CHAR    = 2'd0;
	localparam logic [1:0] REQ_FLUSH   = 2'd1;
	localparam logic [1:0] REQ_RESTART = 2'd2;

	localparam logic       KIND_DATA   = 1'b0;
	localparam logic       KIND_STATUS = 1'b1;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_INVALID    = 2'd1;
	localparam logic [1:0] ST_AFTER_PAD  = 2'd2;
	localparam logic [1:0] ST_INCOMPLETE = 2'd3;

	localparam logic [1:0] CLS_SYM   = 2'd0;
	localparam logic [1:0] CLS_PAD   = 2'd1;
	localparam logic [1:0] CLS_SPACE = 2'd2;
	localparam logic [1:0] CLS_BAD   = 2'd3;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] char_in;
	} in_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] data_byte;
		logic [1:0] status_code;
		logic       finished_flag;
	} out_t;

	typedef struct packed {
		logic [1:0] cls;
		logic [5:0] val;
	} sym_t;

endpackage

FILE: src/base64_stream_decoder_core.sv
// Streaming base64 decoder, one request per cycle unless the result channel stalls.
// Request channel (req_valid/req_ready, req): a character, a flush check or
// a restart. Result channel (res_valid/res_ready, res): a decoded byte or a
// status report; each request gives at most one result.
// A request accepted lands in the input register; its result is registered
// in the result register when the request advances, and shown from then on.
// Throughput is one request per cycle unless results stall: the single
// decode pass between the input register and the result register updates
// phase, leftover bits, sticky error and padding flag together.
// When the receiver stalls, the result register holds and the input
// register still takes one more request; req_ready drops only when both
// are full and res_ready is low.
// Reset clears both valid flags and the decoder state (phase at bit zero,
// no leftover bits, no error, no padding seen). A restart request does the
// same to the decoder state without a result.
`include "base64_stream_decoder_core_defines.svh"
module base64_stream_decoder_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  b64d_pkg::in_t   req,
	output logic            res_valid,
	input  logic            res_ready,
	output b64d_pkg::out_t  res
);
	import b64d_pkg::*;

	logic  valid_s1;
	in_t   req_s1;
	logic  advance;
	sym_t  sym;
	logic  eng_valid;
	out_t  eng_res;
	logic  out_valid_q;
	out_t  out_q;

	assign advance = valid_s1 && (!out_valid_q || res_ready);
	assign req_ready = !valid_s1 || advance;
	assign res_valid = out_valid_q;
	assign res = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid)
			req_s1 <= req;
	end

	b64d_classify u_classify (
		.char_in (req_s1.char_in),
		.sym     (sym)
	);

	b64d_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.req       (req_s1),
		.sym       (sym),
		.res_valid (eng_valid),
		.res       (eng_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= eng_valid;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= eng_res;
	end

	`B64D_ASSERT_SAME(a_stall_only_when_full, !req_ready, valid_s1 && out_valid_q && !res_ready)
	`B64D_ASSERT_NEXT(a_flush_reports, advance && req_s1.req_type == REQ_FLUSH,
		res_valid && res.result_kind == KIND_STATUS)
	`B64D_ASSERT_NEXT(a_restart_silent, advance && req_s1.req_type == REQ_RESTART, !res_valid)
	`B64D_ASSERT_SAME(a_data_ok, res_valid && res.result_kind == KIND_DATA,
		res.status_code == ST_OK)

endmodule

FILE: src/b64d_classify.sv
module b64d_classify (
	input  logic [7:0]    char_in,
	output b64d_pkg::sym_t sym
);
	import b64d_pkg::*;

	localparam logic [7:0] LOWER_BASE = 8'd26;
	localparam logic [7:0] DIGIT_BASE = 8'd52;

	logic [7:0] tmp;

	always_comb begin
		tmp = 8'd0;
		sym.cls = CLS_BAD;
		sym.val = 6'd0;
		if (char_in inside {[8'h41:8'h5a]}) begin
			tmp = char_in - 8'h41;
			sym.cls = CLS_SYM;
		end else if (char_in inside {[8'h61:8'h7a]}) begin
			tmp = char_in - 8'h61 + LOWER_BASE;
			sym.cls = CLS_SYM;
		end else if (char_in inside {[8'h30:8'h39]}) begin
			tmp = char_in - 8'h30 + DIGIT_BASE;
			sym.cls = CLS_SYM;
		end else if (char_in == 8'h2b) begin
			tmp = 8'd62;
			sym.cls = CLS_SYM;
		end else if (char_in == 8'h2f) begin
			tmp = 8'd63;
			sym.cls = CLS_SYM;
		end else if (char_in == 8'h3d) begin
			sym.cls = CLS_PAD;
		end else if (char_in inside {8'h20, [8'h09:8'h0d]}) begin
			sym.cls = CLS_SPACE;
		end
		sym.val = tmp[5:0];
	end

endmodule

FILE: src/b64d_engine.sv
module b64d_engine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire,
	input  b64d_pkg::in_t   req,
	input  b64d_pkg::sym_t  sym,
	output logic            res_valid,
	output b64d_pkg::out_t  res
);
	import b64d_pkg::*;

	localparam logic [2:0] PH_BIT0 = 3'd0;
	localparam logic [2:0] PH_BIT2 = 3'd1;
	localparam logic [2:0] PH_BIT4 = 3'd2;
	localparam logic [2:0] PH_BIT6 = 3'd3;
	localparam logic [2:0] PH_PAD  = 3'd4;

	logic [2:0] phase_q, phase_d;
	logic [5:0] left_q, left_d;
	logic [1:0] err_q, err_d;
	logic       pad_q, pad_d;

	always_comb begin
		phase_d = phase_q;
		left_d = left_q;
		err_d = err_q;
		pad_d = pad_q;
		res_valid = 1'b0;
		res.result_kind = KIND_STATUS;
		res.data_byte = 8'd0;
		res.status_code = ST_OK;
		res.finished_flag = pad_q;
		case (req.req_type)
			REQ_RESTART: begin
				phase_d = PH_BIT0;
				left_d = 6'd0;
				err_d = ST_OK;
				pad_d = 1'b0;
			end
			REQ_FLUSH: begin
				res_valid = 1'b1;
				if (err_q != ST_OK)
					res.status_code = err_q;
				else if (phase_q inside {PH_BIT2, PH_BIT4, PH_BIT6})
					res.status_code = ST_INCOMPLETE;
			end
			REQ_CHAR: begin
				if (err_q == ST_OK) begin
					case (sym.cls)
						CLS_BAD: begin
							err_d = ST_INVALID;
							res_valid = 1'b1;
							res.status_code = ST_INVALID;
						end
						CLS_PAD: begin
							pad_d = 1'b1;
							phase_d = PH_PAD;
							left_d = 6'd0;
						end
						CLS_SYM: begin
							case (phase_q)
								PH_BIT0: begin
									left_d = sym.val;
									phase_d = PH_BIT2;
								end
								PH_BIT2: begin
									res_valid = 1'b1;
									res.result_kind = KIND_DATA;
									res.data_byte = {left_q, sym.val[5:4]};
									left_d = {2'd0, sym.val[3:0]};
									phase_d = PH_BIT4;
								end
								PH_BIT4: begin
									res_valid = 1'b1;
									res.result_kind = KIND_DATA;
									res.data_byte = {left_q[3:0], sym.val[5:2]};
									left_d = {4'd0, sym.val[1:0]};
									phase_d = PH_BIT6;
								end
								PH_BIT6: begin
									res_valid = 1'b1;
									res.result_kind = KIND_DATA;
									res.data_byte = {left_q[1:0], sym.val};
									left_d = 6'd0;
									phase_d = PH_BIT0;
								end
								default: begin
									err_d = ST_AFTER_PAD;
									res_valid = 1'b1;
									res.status_code = ST_AFTER_PAD;
								end
							endcase
						end
						default: ;
					endcase
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BIT0;
			left_q <= 6'd0;
			err_q <= ST_OK;
			pad_q <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_d;
			left_q <= left_d;
			err_q <= err_d;
			pad_q <= pad_d;
		end
	end

endmodule
